// File: sv/fgi_pkg.sv
// Shared types and constants of the fuzzy gain inference block.
package fgi_pkg;

  // Membership grades and rule strengths: unsigned Q1.8, 0..256.
  typedef logic [8:0] grade_t;

  localparam grade_t GRADE_ONE = 9'd256;

  // Rate breakpoints in raw Q7.8 units.
  localparam logic signed [15:0] RATE_20 = 16'sd5120;
  localparam logic signed [15:0] RATE_10 = 16'sd2560;
  localparam logic signed [15:0] RATE_5  = 16'sd1280;
  localparam logic signed [15:0] ERR_ONE = 16'sd256;

  // Reset values of the centre registers.
  localparam logic signed [15:0] SMALL_RST  = -16'sd12800;
  localparam logic signed [15:0] MEDIUM_RST = 16'sd0;
  localparam logic signed [15:0] BIG_RST    = 16'sd12800;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_SMALL  = 2'd0,
    REG_MEDIUM = 2'd1,
    REG_BIG    = 2'd2
  } reg_idx_t;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Divider geometry: quotient bits, divisor bits and dividend magnitude bits.
  localparam int QW   = 16;
  localparam int DENW = 10;
  localparam int MAGW = 25;

  // Clock edges from the accepting edge to the edge that takes the result.
  localparam int LATENCY = 22;

  // Rule strengths of one sample.
  typedef struct packed {
    grade_t s;
    grade_t m;
    grade_t b;
  } rule_t;

endpackage

// File: sv/fgi_front.sv
// Front part: input capture, fuzzification and the min/max rule table.
module fgi_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [15:0]       in_error_value,
  input  logic signed [15:0]       in_error_rate,
  input  logic [fgi_pkg::QCW-1:0]  q_count,
  output logic                     push,
  output fgi_pkg::rule_t           push_data
);
  import fgi_pkg::*;

  logic              a_v_r;
  logic signed [15:0] a_e_r;
  logic signed [15:0] a_d_r;

  grade_t en, ez, ep, nb, ns, zr, ps, pb;
  logic              b_v_r;
  grade_t            en_r, ez_r, ep_r, nb_r, ns_r, zr_r, ps_r, pb_r;

  logic signed [16:0] e17, d17;
  logic signed [16:0] dist_nb, dist_ns_lo, dist_ns_hi, dist_zr_lo, dist_zr_hi;
  logic signed [16:0] dist_ps_lo, dist_ps_hi, dist_pb, dist_en;
  logic [QCW+1:0]     occupancy;
  logic               accept;
  grade_t             side, outer, inner;

  // Division by 10 and by 5 of a distance below 2560, by reciprocal multiplication.
  function automatic grade_t div10(logic [11:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'(14'd6554);
    return grade_t'(p[25:16]);
  endfunction

  function automatic grade_t div5(logic [11:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'(15'd13108);
    return grade_t'(p[26:16]);
  endfunction

  function automatic grade_t gmin(grade_t x, grade_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic grade_t gmax(grade_t x, grade_t y);
    return (x > y) ? x : y;
  endfunction

  // Every item in flight must find a queue slot even if the back never pops.
  assign occupancy = (QCW+2)'(q_count) + (QCW+2)'(a_v_r) + (QCW+2)'(b_v_r);
  assign busy      = !rst_n || (occupancy >= (QCW+2)'(QDEPTH));
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
    end
    if (accept) begin
      a_e_r <= in_error_value;
      a_d_r <= in_error_rate;
    end
  end

  always_comb begin
    e17        = 17'(a_e_r);
    d17        = 17'(a_d_r);
    dist_en    = 17'sd0 - e17;
    dist_nb    = -17'(RATE_10) - d17;
    dist_ns_lo = d17 + 17'(RATE_20);
    dist_ns_hi = -17'(RATE_5) - d17;
    dist_zr_lo = d17 + 17'(RATE_5);
    dist_zr_hi = 17'(RATE_5) - d17;
    dist_ps_lo = d17 - 17'(RATE_5);
    dist_ps_hi = 17'(RATE_20) - d17;
    dist_pb    = d17 - 17'(RATE_10);

    // Error sets over -1..1 have a slope length of exactly 1.0.
    if (a_e_r <= -ERR_ONE)   en = GRADE_ONE;
    else if (a_e_r >= 16'sd0) en = '0;
    else                      en = grade_t'(dist_en[8:0]);

    if (a_e_r <= -ERR_ONE || a_e_r >= ERR_ONE) ez = '0;
    else if (a_e_r == 16'sd0)                  ez = GRADE_ONE;
    else if (a_e_r < 16'sd0)                   ez = grade_t'(e17 + 17'(ERR_ONE));
    else                                       ez = grade_t'(17'(ERR_ONE) - e17);

    if (a_e_r <= 16'sd0)      ep = '0;
    else if (a_e_r >= ERR_ONE) ep = GRADE_ONE;
    else                       ep = grade_t'(e17[8:0]);

    if (a_d_r <= -RATE_20)      nb = GRADE_ONE;
    else if (a_d_r >= -RATE_10) nb = '0;
    else                        nb = div10(dist_nb[11:0]);

    if (a_d_r <= -RATE_20 || a_d_r >= -RATE_5) ns = '0;
    else if (a_d_r == -RATE_10)                ns = GRADE_ONE;
    else if (a_d_r < -RATE_10)                 ns = div10(dist_ns_lo[11:0]);
    else                                       ns = div5(dist_ns_hi[11:0]);

    if (a_d_r <= -RATE_5 || a_d_r >= RATE_5) zr = '0;
    else if (a_d_r == 16'sd0)                zr = GRADE_ONE;
    else if (a_d_r < 16'sd0)                 zr = div5(dist_zr_lo[11:0]);
    else                                     zr = div5(dist_zr_hi[11:0]);

    if (a_d_r <= RATE_5 || a_d_r >= RATE_20) ps = '0;
    else if (a_d_r == RATE_10)               ps = GRADE_ONE;
    else if (a_d_r < RATE_10)                ps = div5(dist_ps_lo[11:0]);
    else                                     ps = div10(dist_ps_hi[11:0]);

    if (a_d_r <= RATE_10)      pb = '0;
    else if (a_d_r >= RATE_20) pb = GRADE_ONE;
    else                       pb = div10(dist_pb[11:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
    en_r <= en;
    ez_r <= ez;
    ep_r <= ep;
    nb_r <= nb;
    ns_r <= ns;
    zr_r <= zr;
    ps_r <= ps;
    pb_r <= pb;
  end

  // Negative and positive error rows share the same consequents.
  always_comb begin
    side        = gmax(en_r, ep_r);
    outer       = gmax(gmax(nb_r, ps_r), pb_r);
    inner       = gmax(ns_r, zr_r);
    push_data.s = gmin(ez_r, zr_r);
    push_data.m = gmax(gmin(side, inner),
                       gmax(gmin(ez_r, gmax(nb_r, ns_r)), gmin(ez_r, gmax(ps_r, pb_r))));
    push_data.b = gmin(side, outer);
  end

  assign push = b_v_r;

endmodule

// File: sv/fgi_queue.sv
// Short queue of rule strengths between the front and the back.
module fgi_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  fgi_pkg::rule_t           push_data,
  input  logic                     pop,
  output logic                     pop_valid,
  output fgi_pkg::rule_t           pop_data,
  output logic [fgi_pkg::QCW-1:0]  count
);
  import fgi_pkg::*;

  rule_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
  assign count_nxt  = count_r + QCW'(push) - QCW'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_valid = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];
  assign count     = count_r;

endmodule

// File: sv/fgi_back.sv
// Back part: weighted sum of the centres and a pipelined restoring divider.
module fgi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  fgi_pkg::rule_t      in_rule,
  input  logic signed [15:0]  small_centre,
  input  logic signed [15:0]  medium_centre,
  input  logic signed [15:0]  big_centre,
  output logic                out_valid,
  output logic signed [15:0]  out_adjustment,
  output logic                out_no_rule_fired
);
  import fgi_pkg::*;

  // Product stage.
  logic               p_v_r;
  logic signed [25:0] p_s_r, p_m_r, p_b_r;
  logic [DENW-1:0]    p_den_r;

  // Divider stages; index 0 is loaded by the sum stage.
  logic               dv_v_r    [QW+1];
  logic [MAGW-1:0]    dv_rem_r  [QW+1];
  logic [QW-1:0]      dv_q_r    [QW+1];
  logic [DENW-1:0]    dv_den_r  [QW+1];
  logic               dv_neg_r  [QW+1];
  logic               dv_zero_r [QW+1];

  logic signed [26:0] num;
  logic [26:0]        num_mag;

  logic               out_v_r;
  logic signed [15:0] out_adj_r;
  logic               out_flag_r;
  logic [QW-1:0]      q_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= in_valid;
    end
    p_s_r   <= $signed({1'b0, in_rule.s}) * small_centre;
    p_m_r   <= $signed({1'b0, in_rule.m}) * medium_centre;
    p_b_r   <= $signed({1'b0, in_rule.b}) * big_centre;
    p_den_r <= DENW'(in_rule.s) + DENW'(in_rule.m) + DENW'(in_rule.b);
  end

  always_comb begin
    num     = 27'(p_s_r) + 27'(p_m_r) + 27'(p_b_r);
    num_mag = num[26] ? 27'(-num) : 27'(num);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= p_v_r;
    end
    dv_rem_r[0]  <= num_mag[MAGW-1:0];
    dv_q_r[0]    <= '0;
    dv_den_r[0]  <= p_den_r;
    dv_neg_r[0]  <= num[26];
    dv_zero_r[0] <= (p_den_r == '0);
  end

  // Stage k decides quotient bit QW-1-k; the quotient stays below 2^QW.
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    logic [MAGW:0] den_sh;
    logic [MAGW:0] diff;
    logic          fits;
    logic [QW-1:0] q_bit;

    always_comb begin
      den_sh = (MAGW+1)'(dv_den_r[k]) << SH;
      diff   = (MAGW+1)'(dv_rem_r[k]) - den_sh;
      fits   = ((MAGW+1)'(dv_rem_r[k]) >= den_sh);
      q_bit  = QW'(fits) << SH;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      dv_rem_r[k+1]     <= fits ? diff[MAGW-1:0] : dv_rem_r[k];
      dv_q_r[k+1]       <= dv_q_r[k] | q_bit;
      dv_den_r[k+1]     <= dv_den_r[k];
      dv_neg_r[k+1]     <= dv_neg_r[k];
      dv_zero_r[k+1]    <= dv_zero_r[k];
    end
  end

  assign q_final = dv_q_r[QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= dv_v_r[QW];
    end
    if (dv_zero_r[QW]) begin
      out_adj_r  <= '0;
      out_flag_r <= 1'b1;
    end else begin
      out_adj_r  <= dv_neg_r[QW] ? $signed(16'(-q_final)) : $signed(q_final);
      out_flag_r <= 1'b0;
    end
  end

  assign out_valid         = out_v_r;
  assign out_adjustment    = out_adj_r;
  assign out_no_rule_fired = out_flag_r;

endmodule

// File: sv/fuzzy_gain_inference.sv
// Top level of the fuzzy gain inference block: configuration registers and wiring.
//
// A sample (in_error_value, in_error_rate, both signed Q7.8) is taken at a rising
// edge where start is high and busy is low. The front fuzzifies the sample and
// evaluates the rule table in two register stages, then writes the rule
// strengths into a four-entry queue. The back reads the queue, forms the
// weighted sum of the three centres and divides by the strength total in a
// sixteen-stage restoring divider, one quotient bit per stage.
// The result shows on out_adjustment and out_no_rule_fired for exactly one
// cycle with out_valid high; it is taken at the edge ending that cycle. A new
// sample may be started every cycle; the back drains one entry per cycle, so
// the queue never fills and busy stays low outside reset. The receiver cannot
// stall the result channel. Centres are written over the APB-style port at
// byte addresses 0, 4 and 8 (small, medium, big) and read back sign-extended;
// they should change only while no transaction is in flight. Synchronous
// reset empties the pipeline and queue, restores the default centres and
// holds busy high.
module fuzzy_gain_inference (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_error_value,
  input  logic signed [15:0] in_error_rate,
  output logic               out_valid,
  output logic signed [15:0] out_adjustment,
  output logic               out_no_rule_fired,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import fgi_pkg::*;

  logic signed [15:0] small_r, medium_r, big_r;
  logic               wr_en;
  reg_idx_t           idx;

  logic               push;
  rule_t              push_data;
  logic               q_valid;
  rule_t              q_data;
  logic [QCW-1:0]     q_count;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_r  <= SMALL_RST;
      medium_r <= MEDIUM_RST;
      big_r    <= BIG_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SMALL:  small_r  <= $signed(pwdata[15:0]);
        REG_MEDIUM: medium_r <= $signed(pwdata[15:0]);
        REG_BIG:    big_r    <= $signed(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SMALL:  prdata = 32'(small_r);
      REG_MEDIUM: prdata = 32'(medium_r);
      REG_BIG:    prdata = 32'(big_r);
      default:    prdata = '0;
    endcase
  end

  fgi_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_error_value (in_error_value),
    .in_error_rate  (in_error_rate),
    .q_count        (q_count),
    .push           (push),
    .push_data      (push_data)
  );

  fgi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_valid),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .count     (q_count)
  );

  fgi_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (q_valid),
    .in_rule           (q_data),
    .small_centre      (small_r),
    .medium_centre     (medium_r),
    .big_centre        (big_r),
    .out_valid         (out_valid),
    .out_adjustment    (out_adjustment),
    .out_no_rule_fired (out_no_rule_fired)
  );

endmodule

// File: sv/fgi_checker.sv
// Port-level checks of the fuzzy gain inference block and their binding.
module fgi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_adjustment,
  input logic               out_no_rule_fired
);
  import fgi_pkg::*;

  // Reset empties the pipeline: no result may follow a reset cycle.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // The queue drains every cycle, so busy falls as soon as reset ends.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised outside reset");

  // Every result comes from a transaction taken a fixed number of edges earlier.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching transaction");

  // When no rule fires the adjustment must read as zero.
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_no_rule_fired) |-> (out_adjustment == 16'sd0))
    else $error("no_rule_fired with a nonzero adjustment");

endmodule

bind fuzzy_gain_inference fgi_checker u_fgi_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_adjustment    (out_adjustment),
  .out_no_rule_fired (out_no_rule_fired)
);

// File: sim/tb_fuzzy_gain_inference.sv
// Self-checking testbench for fuzzy_gain_inference: directed samples, then random samples.
module tb_fuzzy_gain_inference;
  timeunit 1ns;
  timeprecision 1ps;

  import fgi_pkg::*;

  localparam int PHASES            = 6;
  localparam int SAMPLES_PER_PHASE = 335;
  localparam int UNUSED_IDX        = 3;
  localparam int DRAIN_LIMIT       = 10 * LATENCY + 100;
  localparam int MAX_REPORTS       = 50;
  localparam int NROWS             = 22;

  localparam int ONE = GRADE_ONE;
  localparam int E1  = ERR_ONE;
  localparam int R5  = RATE_5;
  localparam int R10 = RATE_10;
  localparam int R20 = RATE_20;

  typedef struct packed {
    logic signed [15:0] adj;
    logic               no_rule;
  } gain_t;

  typedef struct {
    logic signed [15:0] err;
    logic signed [15:0] rate;
    bit                 typed;
    gain_t              want;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_error_value = '0;
  logic signed [15:0] in_error_rate = '0;
  logic out_valid;
  logic signed [15:0] out_adjustment;
  logic out_no_rule_fired;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Centre values as the block should currently hold them.
  logic signed [15:0] centre_small = SMALL_RST;
  logic signed [15:0] centre_medium = MEDIUM_RST;
  logic signed [15:0] centre_big = BIG_RST;

  gain_t pending_gains[$];
  int errors = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int silent_samples = 0;
  int settings_used = 1;
  int burst_left = 0;

  // Expected results are typed in only where they follow directly from the rule table.
  sample_row_t directed_rows [NROWS] = '{
    '{16'sd0,     16'sd0,     1'b1, '{SMALL_RST, 1'b0}},
    '{16'sd0,     16'sd1280,  1'b1, '{16'sd0, 1'b1}},
    '{16'sd0,     -16'sd1280, 1'b1, '{16'sd0, 1'b1}},
    '{16'sd0,     16'sd1279,  1'b1, '{16'sd0, 1'b1}},
    '{16'sd0,     -16'sd1279, 1'b1, '{16'sd0, 1'b1}},
    '{16'sh7FFF,  16'sh7FFF,  1'b1, '{BIG_RST, 1'b0}},
    '{16'sh8000,  16'sh8000,  1'b1, '{BIG_RST, 1'b0}},
    '{16'sh8000,  16'sd0,     1'b1, '{MEDIUM_RST, 1'b0}},
    '{16'sd0,     16'sh7FFF,  1'b1, '{MEDIUM_RST, 1'b0}},
    '{16'sd256,   16'sd2560,  1'b1, '{BIG_RST, 1'b0}},
    '{16'sd128,   16'sd0,     1'b1, '{-16'sd6400, 1'b0}},
    '{16'sh7FFF,  16'sd1280,  1'b1, '{16'sd0, 1'b1}},
    '{-16'sd256,  -16'sd2560, 1'b0, '{16'sd0, 1'b0}},
    '{16'sd255,   16'sd5120,  1'b0, '{16'sd0, 1'b0}},
    '{-16'sd255,  -16'sd5120, 1'b0, '{16'sd0, 1'b0}},
    '{16'sd1,     16'sd10,    1'b0, '{16'sd0, 1'b0}},
    '{-16'sd1,    -16'sd10000, 1'b0, '{16'sd0, 1'b0}},
    '{16'sh8000,  16'sh7FFF,  1'b0, '{16'sd0, 1'b0}},
    '{16'sh7FFF,  16'sh8000,  1'b0, '{16'sd0, 1'b0}},
    '{16'sd100,   16'sd3000,  1'b0, '{16'sd0, 1'b0}},
    '{-16'sd200,  -16'sd1500, 1'b0, '{16'sd0, 1'b0}},
    '{16'sd50,    -16'sd3500, 1'b0, '{16'sd0, 1'b0}}
  };

  fuzzy_gain_inference dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_error_value   (in_error_value),
    .in_error_rate    (in_error_rate),
    .out_valid        (out_valid),
    .out_adjustment   (out_adjustment),
    .out_no_rule_fired(out_no_rule_fired),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int weaker(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int stronger(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int fall_grade(int x, int lo, int hi);
    if (x <= lo) return ONE;
    if (x >= hi) return 0;
    return ((hi - x) * ONE) / (hi - lo);
  endfunction

  function automatic int rise_grade(int x, int lo, int hi);
    if (x <= lo) return 0;
    if (x >= hi) return ONE;
    return ((x - lo) * ONE) / (hi - lo);
  endfunction

  function automatic int peak_grade(int x, int a, int b, int c);
    if (x <= a || x >= c) return 0;
    if (x == b) return ONE;
    if (x < b) return ((x - a) * ONE) / (b - a);
    return ((c - x) * ONE) / (c - b);
  endfunction

  function automatic gain_t predict_gain(logic signed [15:0] e_in, logic signed [15:0] r_in);
    int e, r, en, ez, ep, nb, ns, zr, ps, pb;
    int side, outer, inner, s, m, b, den, num;
    gain_t g;
    e = e_in;
    r = r_in;
    en = fall_grade(e, -E1, 0);
    ez = peak_grade(e, -E1, 0, E1);
    ep = rise_grade(e, 0, E1);
    nb = fall_grade(r, -R20, -R10);
    ns = peak_grade(r, -R20, -R10, -R5);
    zr = peak_grade(r, -R5, 0, R5);
    ps = peak_grade(r, R5, R10, R20);
    pb = rise_grade(r, R10, R20);
    // Negative and positive error rows fire the same consequents.
    side = stronger(en, ep);
    outer = stronger(stronger(nb, ps), pb);
    inner = stronger(ns, zr);
    s = weaker(ez, zr);
    m = stronger(weaker(side, inner),
                 stronger(weaker(ez, stronger(nb, ns)), weaker(ez, stronger(ps, pb))));
    b = weaker(side, outer);
    den = s + m + b;
    if (den == 0) begin
      g.adj = '0;
      g.no_rule = 1'b1;
    end else begin
      num = s * int'(centre_small) + m * int'(centre_medium) + b * int'(centre_big);
      g.adj = 16'(num / den);
      g.no_rule = 1'b0;
    end
    return g;
  endfunction

  function automatic logic signed [15:0] pick_error();
    int k, v;
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 640)) - 320;
      6: begin
        case ($urandom_range(0, 3))
          0: v = E1;
          1: v = E1 - 1;
          2: v = 1;
          default: v = 0;
        endcase
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] pick_rate();
    int k, v;
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2, 3, 4: v = int'($urandom_range(0, 12800)) - 6400;
      5: begin
        case ($urandom_range(0, 3))
          0: v = R20;
          1: v = R10;
          2: v = R5;
          default: v = 0;
        endcase
        v = v + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      // At and just inside the zero set's feet, where the grade truncates to zero or near it.
      6: begin
        v = R5 - int'($urandom_range(0, 8));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return 16'(v);
  endfunction

  // Bursts of back-to-back samples separated by idle gaps of random length.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic send_sample(input logic signed [15:0] e, input logic signed [15:0] r,
                             input bit typed, input gain_t want);
    bit taken;
    gain_t g;
    in_error_value <= e;
    in_error_rate <= r;
    start <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      // busy cannot change between the falling edge and the next rising edge.
      @(negedge clk);
      taken = !busy;
      if (taken) begin
        g = typed ? want : predict_gain(e, r);
        pending_gains.push_back(g);
        samples_sent++;
        if (g.no_rule) silent_samples++;
      end
      @(posedge clk);
    end
  endtask

  task automatic write_centre(input int idx, input logic signed [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx * 4);
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (pready !== 1'b1);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == int'(REG_SMALL)) centre_small = value;
    else if (idx == int'(REG_MEDIUM)) centre_medium = value;
    else if (idx == int'(REG_BIG)) centre_big = value;
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (pending_gains.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    gain_t want;
    if (rst_n && out_valid) begin
      if (pending_gains.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual adjustment=%0d flag=%0b",
                   $time, out_adjustment, out_no_rule_fired);
      end else begin
        want = pending_gains.pop_front();
        results_seen++;
        if (out_adjustment !== want.adj) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: adjustment mismatch, expected %0d, actual %0d",
                     $time, want.adj, out_adjustment);
        end
        if (out_no_rule_fired !== want.no_rule) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: no_rule_fired mismatch, expected %0b, actual %0b",
                     $time, want.no_rule, out_no_rule_fired);
        end
      end
    end
  end

  initial begin
    logic signed [15:0] vals [3];
    int p, i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NROWS; i++) begin
      pace();
      send_sample(directed_rows[i].err, directed_rows[i].rate,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: vals = '{16'sh8000, 16'sh7FFF, 16'sh8000};
          2: vals = '{16'sh7FFF, 16'sh8000, 16'sh7FFF};
          3: vals = '{16'sd0, 16'sd0, 16'sd0};
          default: vals = '{16'($urandom), 16'($urandom), 16'($urandom)};
        endcase
        write_centre(int'(REG_SMALL), vals[0]);
        write_centre(int'(REG_MEDIUM), vals[1]);
        write_centre(int'(REG_BIG), vals[2]);
        // A write past the last register must leave the centres alone.
        write_centre(UNUSED_IDX, 16'($urandom));
        settings_used++;
      end
      repeat (SAMPLES_PER_PHASE) begin
        pace();
        send_sample(pick_error(), pick_rate(), 1'b0, '0);
      end
    end

    drain();
    if (pending_gains.size() != 0) begin
      errors += pending_gains.size();
      $display("%0t: %0d expected results never arrived", $time, pending_gains.size());
    end
    $display("Checked %0d of %0d samples under %0d centre settings; %0d fired no rule.",
             results_seen, samples_sent, settings_used, silent_samples);
    $display("Mismatches found: %0d", errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: fuzzy_gain_inference.f
sv/fgi_pkg.sv
sv/fgi_front.sv
sv/fgi_queue.sv
sv/fgi_back.sv
sv/fuzzy_gain_inference.sv
sv/fgi_checker.sv
sim/tb_fuzzy_gain_inference.sv
